### sv/spline_inverse_ratio_evaluator_unit_assert.svh
// ----------------------------------------------------------------------------
// Spline inverse ratio evaluator assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPLINE_INVERSE_RATIO_EVALUATOR_UNIT_ASSERT_SVH
`define SPLINE_INVERSE_RATIO_EVALUATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check a property at every rising clock edge
`define SIRE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sire: assertion failed");
// check that a condition implies another in the next cycle
`define SIRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sire: assertion failed");
`else
`define SIRE_ASSERT(lbl, prop)
`define SIRE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/sire_pkg.sv
// ----------------------------------------------------------------------------
// Spline inverse ratio evaluator package
// Sizes, payload types, codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sire_pkg;

    localparam int MAX_DIM  = 8;
    localparam int SEGMENTS = 64;

    localparam int NBLK     = MAX_DIM - 1;
    localparam int BP_DEPTH = NBLK * SEGMENTS;
    localparam int CF_DEPTH = BP_DEPTH * 4;
    localparam int BP_AW    = $clog2(BP_DEPTH);
    localparam int CF_AW    = BP_AW + 2;
    localparam int SEG_W    = $clog2(SEGMENTS);
    localparam int BLK_W    = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int DIM1_W   = $clog2(MAX_DIM);
    localparam int DVD_W    = DIM1_W + 54;
    localparam int DCNT_W   = $clog2(DVD_W + 1);

    localparam logic [31:0] KMAX_Q22 = 32'd4194304000;
    localparam logic signed [47:0] KMAX_Q32 = 48'sd4294967296000;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA_LIMIT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLAMP   = 2'd1;
    localparam logic [1:0] ST_BAD_DIM = 2'd2;

    typedef enum logic [1:0] {
        CMD_EVAL  = 2'd0,
        CMD_WR_BP = 2'd1,
        CMD_WR_CF = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RES_INVALID,
        RES_ZERO,
        RES_FULL,
        RES_ASYM,
        RES_SPLINE
    } res_kind_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [3:0]         table_dim;
        logic [7:0]         table_index;
        logic signed [47:0] table_value;
        logic [32:0]        lambda;
    } in_item_t;

    typedef struct packed {
        logic [31:0] kappa;
        logic [1:0]  status;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic      capture;
        logic      write_tbl;
        logic      rd_bp_last;
        logic      scan_init;
        logic      scan_next;
        logic      cf_first;
        logic      acc_load;
        logic      mul_lo;
        logic      mul_hi;
        logic      acc_add;
        logic      div_init;
        logic      div_step;
        logic      finish;
        res_kind_t kind;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic dim_ok;
        logic below;
        logic at_one;
        logic above_last;
        logic scan_hit;
        logic last_term;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

### sv/sire_datapath.sv
// ----------------------------------------------------------------------------
// Spline inverse ratio evaluator datapath
// Table memories, segment scan, Horner accumulator, serial divider and
// the output register.
// ----------------------------------------------------------------------------
module sire_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sire_pkg::in_item_t              in_data,
    input  sire_pkg::ctl_cmd_t              cmd,
    output sire_pkg::dp_status_t            sts,
    input  logic                            cfg_we,
    input  logic [sire_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sire_pkg::out_item_t             out_data
);
    import sire_pkg::*;

    logic [7:0]            dim_reg;
    logic [31:0]           limit_reg;
    in_item_t              item_reg;
    logic [32:0]           bp_mem [BP_DEPTH];
    logic signed [47:0]    cf_mem [CF_DEPTH];
    logic [32:0]           bp_q_reg;
    logic signed [47:0]    cf_q_reg;
    logic [SEG_W-1:0]      cnt_reg;
    logic [1:0]            term_reg;
    logic signed [47:0]    acc_reg;
    logic [63:0]           p_lo_reg;
    logic [63:0]           p_hi_reg;
    logic [32:0]           rem_reg;
    logic [32:0]           dsr_reg;
    logic [DVD_W-1:0]      dvd_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic [BLK_W-1:0]      ev_blk;
    logic [BP_AW-1:0]      ev_base;
    logic [BLK_W-1:0]      ld_blk;
    logic [BP_AW-1:0]      ld_base;
    logic                  ld_dim_ok;
    logic                  bp_we;
    logic                  cf_we;
    logic [BP_AW-1:0]      bp_wr_addr;
    logic [CF_AW-1:0]      cf_wr_addr;
    logic                  bp_rd_en;
    logic [BP_AW-1:0]      bp_rd_addr;
    logic                  cf_rd_en;
    logic [1:0]            cf_rd_term;
    logic [CF_AW-1:0]      cf_rd_addr;
    logic [40:0]           dl_prod;
    logic                  acc_neg;
    logic [47:0]           acc_mag;
    logic [63:0]           m_sum;
    logic [47:0]           m_val;
    logic signed [49:0]    sum_w;
    logic signed [47:0]    sum_sat;
    logic [33:0]           div_r;
    logic                  div_ge;
    logic [31:0]           raw_kappa;
    logic [1:0]            raw_status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= 8'd2;
            limit_reg <= KMAX_Q22;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIMENSION:   dim_reg   <= cfg_data[7:0];
                CFG_KAPPA_LIMIT: limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
    end

    // decode table block addresses
    assign ev_blk    = BLK_W'(dim_reg - 8'd2);
    assign ev_base   = BP_AW'(ev_blk) * BP_AW'(SEGMENTS);
    assign ld_blk    = BLK_W'(item_reg.table_dim - 4'd2);
    assign ld_base   = BP_AW'(ld_blk) * BP_AW'(SEGMENTS);
    assign ld_dim_ok = (32'(item_reg.table_dim) >= 32'd2)
                    && (32'(item_reg.table_dim) <= 32'(MAX_DIM));

    // table writes
    assign bp_we = cmd.write_tbl && (item_reg.cmd == CMD_WR_BP) && ld_dim_ok
                && (32'(item_reg.table_index) < 32'(SEGMENTS));
    assign cf_we = cmd.write_tbl && (item_reg.cmd == CMD_WR_CF) && ld_dim_ok
                && (32'(item_reg.table_index) < 32'(SEGMENTS * 4));
    assign bp_wr_addr = ld_base + BP_AW'(item_reg.table_index);
    assign cf_wr_addr = {ld_base + BP_AW'(item_reg.table_index[7:2]),
                         item_reg.table_index[1:0]};

    // breakpoint read address
    always_comb
    begin
        bp_rd_en   = cmd.rd_bp_last || cmd.scan_init || cmd.scan_next;
        bp_rd_addr = ev_base + BP_AW'(SEGMENTS - 1);
        if (cmd.scan_init)
            bp_rd_addr = ev_base + BP_AW'(1);
        else if (cmd.scan_next)
            bp_rd_addr = ev_base + BP_AW'(cnt_reg) + BP_AW'(2);
    end

    // coefficient read address
    always_comb
    begin
        cf_rd_en   = cmd.cf_first || cmd.acc_load || (cmd.acc_add && !sts.last_term);
        cf_rd_term = cmd.cf_first ? 2'd0 : term_reg + 2'd1;
        cf_rd_addr = {ev_base + BP_AW'(cnt_reg), cf_rd_term};
    end

    always_ff @(posedge clk)
    begin
        if (bp_we)
            bp_mem[bp_wr_addr] <= item_reg.table_value[32:0];
        if (bp_rd_en)
            bp_q_reg <= bp_mem[bp_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cf_we)
            cf_mem[cf_wr_addr] <= item_reg.table_value;
        if (cf_rd_en)
            cf_q_reg <= cf_mem[cf_rd_addr];
    end

    // Horner step arithmetic
    assign acc_neg = acc_reg[47];
    assign acc_mag = acc_neg ? 48'(-acc_reg) : 48'(acc_reg);
    assign m_sum   = p_hi_reg + (p_lo_reg >> 16);
    assign m_val   = m_sum[63:16];
    assign sum_w   = (acc_neg ? -$signed({2'b00, m_val}) : $signed({2'b00, m_val}))
                   + 50'(cf_q_reg);

    always_comb
    begin
        if (sum_w > 50'sh0_7FFF_FFFF_FFFF)
            sum_sat = 48'sh7FFF_FFFF_FFFF;
        else if (sum_w < -50'sh0_8000_0000_0000)
            sum_sat = 48'sh8000_0000_0000;
        else
            sum_sat = sum_w[47:0];
    end

    // divider step
    assign div_r  = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge = div_r >= {1'b0, dsr_reg};

    // scan, Horner and divider registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            term_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.scan_init)
                cnt_reg <= '0;
            else if (cmd.scan_next)
                cnt_reg <= cnt_reg + SEG_W'(1);
            if (cmd.cf_first)
                term_reg <= 2'd0;
            else if (cmd.acc_load || (cmd.acc_add && !sts.last_term))
                term_reg <= term_reg + 2'd1;
            if (cmd.div_init)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_load)
            acc_reg <= cf_q_reg;
        else if (cmd.acc_add)
            acc_reg <= sum_sat;
        if (cmd.mul_lo)
            p_lo_reg <= 64'(acc_mag) * 64'(item_reg.lambda[15:0]);
        if (cmd.mul_hi)
            p_hi_reg <= 64'(acc_mag) * 64'(item_reg.lambda[31:16]);
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            dsr_reg <= ONE_Q32 - item_reg.lambda;
            dvd_reg <= {DIM1_W'(dim_reg - 8'd1), 54'd0};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? 33'(div_r - {1'b0, dsr_reg}) : div_r[32:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], div_ge};
        end
    end

    // status to the controller
    assign dl_prod = 41'(dim_reg) * 41'(item_reg.lambda);

    always_comb
    begin
        sts.cmd        = item_reg.cmd;
        sts.dim_ok     = (dim_reg >= 8'd2) && (32'(dim_reg) <= 32'(MAX_DIM));
        sts.below      = dl_prod < 41'(ONE_Q32);
        sts.at_one     = item_reg.lambda[32];
        sts.above_last = item_reg.lambda > bp_q_reg;
        sts.scan_hit   = (item_reg.lambda < bp_q_reg)
                      || (cnt_reg == SEG_W'(SEGMENTS - 2));
        sts.last_term  = term_reg == 2'd3;
        sts.div_done   = dcnt_reg == DCNT_W'(DVD_W);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // result selection
    always_comb
    begin
        raw_kappa  = '0;
        raw_status = ST_OK;
        unique case (cmd.kind)
            RES_INVALID: raw_status = ST_BAD_DIM;
            RES_ZERO:    raw_kappa  = '0;
            RES_FULL:    raw_kappa  = KMAX_Q22;
            RES_ASYM:    raw_kappa  = (dvd_reg > DVD_W'(KMAX_Q22)) ? KMAX_Q22
                                                                 : dvd_reg[31:0];
            RES_SPLINE:
            begin
                if (acc_reg < 0)
                begin
                    raw_kappa  = '0;
                    raw_status = ST_CLAMP;
                end
                else if (acc_reg > KMAX_Q32)
                begin
                    raw_kappa  = KMAX_Q22;
                    raw_status = ST_CLAMP;
                end
                else
                    raw_kappa = acc_reg[41:10];
            end
            default:     raw_status = ST_OK;
        endcase
    end

    // output register: load on finish, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.kappa  <= (raw_kappa > limit_reg) ? limit_reg : raw_kappa;
            out_reg.status <= raw_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### sv/sire_ctrl.sv
// ----------------------------------------------------------------------------
// Spline inverse ratio evaluator controller
// Sequences decode, breakpoint scan, Horner steps, division and result.
// ----------------------------------------------------------------------------
module sire_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sire_pkg::dp_status_t  sts,
    output sire_pkg::ctl_cmd_t    cmd
);
    import sire_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CMP_LAST,
        S_SCAN,
        S_ACC_LOAD,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC_ADD,
        S_DIV,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_WR_BP, CMD_WR_CF:
                    begin
                        cmd.write_tbl = 1'b1;
                        state_next    = S_IDLE;
                    end
                    CMD_EVAL:
                    begin
                        if (!sts.dim_ok)
                        begin
                            kind_next  = RES_INVALID;
                            state_next = S_FINISH;
                        end
                        else if (sts.below)
                        begin
                            kind_next  = RES_ZERO;
                            state_next = S_FINISH;
                        end
                        else if (sts.at_one)
                        begin
                            kind_next  = RES_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_bp_last = 1'b1;
                            state_next     = S_CMP_LAST;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_CMP_LAST:
            begin
                if (sts.above_last)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.cf_first = 1'b1;
                    state_next   = S_ACC_LOAD;
                end
                else
                    cmd.scan_next = 1'b1;
            end
            S_ACC_LOAD:
            begin
                cmd.acc_load = 1'b1;
                state_next   = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_ACC_ADD;
            end
            S_ACC_ADD:
            begin
                cmd.acc_add = 1'b1;
                if (sts.last_term)
                begin
                    kind_next  = RES_SPLINE;
                    state_next = S_FINISH;
                end
                else
                    state_next = S_MUL_LO;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    kind_next  = RES_ASYM;
                    state_next = S_FINISH;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold state and result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

### sv/spline_inverse_ratio_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Spline inverse ratio evaluator
// Inverts a ratio function with loadable piecewise cubic spline tables.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall/in_data) carries load and evaluate
//   items; a transfer happens when in_valid is high and in_stall is low.
//   Loads write one breakpoint or coefficient and produce no result.
//   Each evaluate produces one result on out_valid/out_stall/out_data.
//   Registers dimension and kappa_limit are written through cfg_we,
//   cfg_index and cfg_data; the user must write them only while the block
//   is idle, which the block does not enforce. Loads and ignored commands
//   end after decode; an evaluate in a fixed region (invalid dimension,
//   below 1/dimension, at or above 1.0) goes from decode to the result.
//   The asymptote region runs the restoring divider one quotient bit per
//   cycle. A spline evaluate scans breakpoints one per cycle through the
//   read port (up to 63), then 3 Horner steps: multiply low, high, add.
//   One item is in work at a time; the next is taken as soon as the
//   controller is idle, even while a result waits in the output register.
//   Reset clears control state and sets dimension 2 and kappa_limit 1000.0;
//   table contents are undefined until loaded. A stalled receiver holds the
//   result; a finished item then waits until the register frees.
// ----------------------------------------------------------------------------
`include "spline_inverse_ratio_evaluator_unit_assert.svh"

module spline_inverse_ratio_evaluator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sire_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sire_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [sire_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import sire_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t sts;

    sire_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sire_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // block goes busy after every accepted item
    `SIRE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // results never exceed 1000.0
    `SIRE_ASSERT(a_kappa_range, !out_valid || (out_data.kappa <= KMAX_Q22))
    // an invalid dimension always yields zero
    `SIRE_ASSERT(a_bad_dim_zero, !out_valid || (out_data.status != ST_BAD_DIM) || (out_data.kappa == '0))

endmodule

### test/spline_inverse_ratio_evaluator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spline inverse ratio evaluator testbench
// Loads spline tables, drives evaluate and load items with random idling on
// both channels and compares every result with a table-based kappa predictor.
// ----------------------------------------------------------------------------
module spline_inverse_ratio_evaluator_unit_test;
    import sire_pkg::*;

    class kappa_scoreboard;
        logic [32:0]        bp_table [BP_DEPTH];
        logic signed [47:0] cf_table [CF_DEPTH];
        logic [7:0]         dimension;
        logic [31:0]        kappa_limit;
        out_item_t          pending_kappa [$];
        int                 errors;

        function new();
            dimension = 8'd2;
            kappa_limit = KMAX_Q22;
            errors = 0;
        endfunction

        // multiply a Q15.32 value by lambda, truncating the magnitude
        function automatic logic signed [63:0] scale_by_lambda(logic signed [63:0] acc,
                                                              logic [31:0] lam);
            logic [63:0] mag;
            logic [63:0] prod;
            mag = (acc < 0) ? -acc : acc;
            prod = (mag * lam[31:16] + ((mag * lam[15:0]) >> 16)) >> 16;
            return (acc < 0) ? -$signed(prod) : $signed(prod);
        endfunction

        // note an accepted input transfer: update tables or predict a result
        function void note_input(in_item_t it);
            int blk;
            int seg;
            logic signed [63:0] acc;
            logic [63:0] q;
            out_item_t r;
            blk = int'(it.table_dim) - 2;
            if (it.cmd == CMD_WR_BP || it.cmd == CMD_WR_CF)
            begin
                if (it.table_dim >= 2 && it.table_dim <= MAX_DIM)
                begin
                    if (it.cmd == CMD_WR_BP && it.table_index < SEGMENTS)
                        bp_table[blk * SEGMENTS + it.table_index] = it.table_value[32:0];
                    else if (it.cmd == CMD_WR_CF)
                        cf_table[blk * SEGMENTS * 4 + it.table_index] = it.table_value;
                end
                return;
            end
            if (it.cmd == CMD_NOP)
                return;
            r.kappa = 32'd0;
            r.status = ST_OK;
            if (dimension < 2 || dimension > MAX_DIM)
                r.status = ST_BAD_DIM;
            else
            begin
                blk = int'(dimension) - 2;
                if (64'(dimension) * 64'(it.lambda) < 64'(ONE_Q32))
                    r.kappa = 32'd0;
                else if (it.lambda >= ONE_Q32)
                    r.kappa = KMAX_Q22;
                else if (it.lambda > bp_table[blk * SEGMENTS + SEGMENTS - 1])
                begin
                    q = (64'(dimension - 1) << 54) / (64'(ONE_Q32) - 64'(it.lambda));
                    r.kappa = (q > 64'(KMAX_Q22)) ? KMAX_Q22 : q[31:0];
                end
                else
                begin
                    seg = SEGMENTS - 2;
                    for (int s = 0; s + 1 < SEGMENTS; s++)
                        if (it.lambda < bp_table[blk * SEGMENTS + s + 1])
                        begin
                            seg = s;
                            break;
                        end
                    acc = cf_table[(blk * SEGMENTS + seg) * 4];
                    for (int t = 1; t < 4; t++)
                    begin
                        acc = scale_by_lambda(acc, it.lambda[31:0])
                            + cf_table[(blk * SEGMENTS + seg) * 4 + t];
                        if (acc > 64'sh7FFF_FFFF_FFFF)
                            acc = 64'sh7FFF_FFFF_FFFF;
                        else if (acc < -64'sh8000_0000_0000)
                            acc = -64'sh8000_0000_0000;
                    end
                    if (acc < 0)
                        r.status = ST_CLAMP;
                    else if (acc > 64'(KMAX_Q32))
                    begin
                        r.kappa = KMAX_Q22;
                        r.status = ST_CLAMP;
                    end
                    else
                        r.kappa = acc[41:10];
                end
            end
            if (r.kappa > kappa_limit)
                r.kappa = kappa_limit;
            pending_kappa.push_back(r);
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_kappa.size() == 0)
            begin
                $display("%0t: unexpected result kappa %0d status %0d",
                         $time, got.kappa, got.status);
                errors++;
                return;
            end
            want = pending_kappa.pop_front();
            if (got.kappa !== want.kappa)
            begin
                $display("%0t: kappa expected %0d actual %0d", $time, want.kappa, got.kappa);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    kappa_scoreboard board;
    bit quiet_tail;
    bit hold_receiver;
    int filled_dims [3] = '{2, 5, 8};
    logic [32:0] bp_shadow [2:MAX_DIM][SEGMENTS];

    spline_inverse_ratio_evaluator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // end the run with a mismatch if the block hangs
    initial
    begin
        #40ms;
        $display("spline_inverse_ratio_evaluator_unit: mismatch");
        $finish;
    end

    // check result transfers
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    // receiver stall: random bursts, one long hold, none at the tail
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_receiver = 0;
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one item and wait for its transfer, idling at random first
    task automatic send_item(in_item_t it);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(it);
    endtask

    task automatic load_item(cmd_t c, int d, int idx, logic signed [47:0] v);
        in_item_t it;
        it.cmd = c;
        it.table_dim = 4'(d);
        it.table_index = 8'(idx);
        it.table_value = v;
        it.lambda = 33'($urandom);
        send_item(it);
    endtask

    task automatic eval_item(logic [32:0] lam);
        in_item_t it;
        it.cmd = CMD_EVAL;
        it.table_dim = 4'($urandom);
        it.table_index = 8'($urandom);
        it.table_value = {$urandom, 16'($urandom)};
        it.lambda = lam;
        send_item(it);
    endtask

    // wait for the block to drain, then write a register
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_kappa.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DIMENSION)
            board.dimension = v[7:0];
        else
            board.kappa_limit = v;
    endtask

    function automatic logic signed [47:0] random_coef();
        logic signed [47:0] v;
        case ($urandom_range(0, 5))
            0: v = 48'sh7FFF_FFFF_FFFF;
            1: v = -48'sh8000_0000_0000;
            2: v = -$signed(48'($urandom_range(0, 32'hFFFF_FFFF)));
            default: v = 48'($urandom_range(0, 300)) << 32 | 48'($urandom);
        endcase
        return v;
    endfunction

    // fill a table block with ascending breakpoints and random coefficients
    task automatic fill_block(int d);
        logic [32:0] b;
        for (int s = 0; s < SEGMENTS; s++)
        begin
            b = 33'(s) * 33'h400_0000 + 33'($urandom_range(0, 33'h3FF_FFFF));
            if (s == 0)
                b = 33'd0;
            bp_shadow[d][s] = b;
            load_item(CMD_WR_BP, d, s, 48'(b));
        end
        for (int k = 0; k < SEGMENTS * 4; k++)
            load_item(CMD_WR_CF, d, k, random_coef());
    endtask

    // lambda biased toward breakpoints and region edges
    function automatic logic [32:0] pick_lambda(int d);
        case ($urandom_range(0, 7))
            0: return ONE_Q32 - 33'($urandom_range(0, 1000));
            1: return bp_shadow[d][$urandom_range(0, SEGMENTS - 1)];
            2: return ONE_Q32 / d - 33'($urandom_range(0, 3));
            3: return {1'b1, 32'($urandom)};
            default: return {1'b0, 32'($urandom)};
        endcase
    endfunction

    initial
    begin
        int d;
        board = new();
        quiet_tail = 0;
        hold_receiver = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_DIMENSION;
        cfg_data = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: load the evaluated blocks, ignored loads, no-op, edge lambdas
        foreach (filled_dims[i])
            fill_block(filled_dims[i]);
        load_item(CMD_WR_BP, 1, 3, 48'sd5);
        load_item(CMD_WR_BP, 9, 3, 48'sd5);
        load_item(CMD_WR_BP, 2, 200, 48'sd5);
        load_item(CMD_NOP, 2, 0, 48'sd0);
        eval_item(33'd0);
        eval_item(ONE_Q32);
        eval_item(33'h1_FFFF_FFFF);
        eval_item(ONE_Q32 - 1);
        eval_item(ONE_Q32 / 2);
        eval_item(bp_shadow[2][SEGMENTS - 1]);
        eval_item(bp_shadow[2][SEGMENTS - 1] + 1);
        eval_item(33'h0_7FFF_FFFF);
        write_register(CFG_DIMENSION, 32'd0);
        eval_item(ONE_Q32 / 2);
        write_register(CFG_DIMENSION, 32'd255);
        eval_item(33'd12345);
        write_register(CFG_DIMENSION, 32'd8);
        write_register(CFG_KAPPA_LIMIT, 32'd0);
        eval_item(ONE_Q32);
        eval_item(pick_lambda(8));
        write_register(CFG_KAPPA_LIMIT, 32'h0100_0000);
        eval_item(ONE_Q32);

        // long receiver hold while items keep coming
        hold_receiver = 1;
        for (int i = 0; i < 30; i++)
            eval_item(pick_lambda(8));

        // random phases across settings
        for (int ph = 0; ph < 12; ph++)
        begin
            d = (ph % 4 == 3) ? $urandom_range(MAX_DIM + 1, 255)
                              : filled_dims[$urandom_range(0, 2)];
            write_register(CFG_DIMENSION, 32'(d));
            write_register(CFG_KAPPA_LIMIT, (ph % 3 == 0) ? KMAX_Q22
                           : 32'($urandom_range(0, KMAX_Q22)));
            if (ph == 9)
                quiet_tail = 1;
            for (int i = 0; i < 70; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_item(cmd_t'($urandom_range(1, 3)), $urandom_range(10, 15),
                              $urandom, random_coef());
                else if (d >= 2 && d <= MAX_DIM && $urandom_range(0, 19) == 0)
                    load_item(CMD_WR_CF, d, $urandom_range(0, SEGMENTS * 4 - 1),
                              random_coef());
                else
                    eval_item(pick_lambda((d >= 2 && d <= MAX_DIM) ? d : 2));
            end
        end

        in_valid <= 1'b0;
        while (board.pending_kappa.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending_kappa.size() == 0)
            $display("spline_inverse_ratio_evaluator_unit: match");
        else
            $display("spline_inverse_ratio_evaluator_unit: mismatch");
        $finish;
    end
endmodule
